>>> design/bwsd_pkg.sv
// Package for the batch work-stealing dispatcher: field widths, codes, types.
// No dependencies; imported by every module of the block.
package bwsd_pkg;

	localparam int MAX_WORKERS_DEF = 16;

	localparam int TOTAL_W     = 31;
	localparam int BATCH_W     = 16;
	localparam int AWK_W       = 5;
	localparam int WORKER_W    = 4;
	localparam int LEN_W       = 16;
	localparam int VIC_W       = 4;
	localparam int CNT_W       = 32;
	localparam int WCNT_W      = 7;   // effective worker count, up to MAX_WORKERS
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 2'd2;

	typedef enum logic [1:0] {
		STS_STARTED = 2'd0,
		STS_OWN     = 2'd1,
		STS_STOLEN  = 2'd2,
		STS_NOWORK  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_START   = 1'b0,
		MODE_REQUEST = 1'b1
	} mode_t;

	typedef enum logic {
		ALU_ADD_SAT = 1'b0,
		ALU_SUB     = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_INIT,
		CS_OWN_RD,
		CS_OWN_EVAL,
		CS_SCAN,
		CS_SCAN_END,
		CS_STEAL,
		CS_LEN,
		CS_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [BATCH_W-1:0] batch;   // effective, never zero
		logic [WCNT_W-1:0]  n;       // effective worker count
	} cfg_t;

	typedef struct packed {
		alu_op_t          op;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [CNT_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] res;
		logic             lt;
	} alu_rsp_t;

	typedef struct packed {
		status_t            status;
		logic [TOTAL_W-1:0] start_index;
		logic [LEN_W-1:0]   length;
		logic [VIC_W-1:0]   victim;
	} res_t;

endpackage

>>> design/bwsd_alu.sv
// Shared 32-bit unit: saturating add or plain subtract, plus a less-than compare.
// Depends on bwsd_pkg.
module bwsd_alu (
	input  bwsd_pkg::alu_req_t req,
	output bwsd_pkg::alu_rsp_t rsp
);
	import bwsd_pkg::*;

	logic [CNT_W:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		unique case (req.op)
			ALU_ADD_SAT: rsp.res = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
			ALU_SUB:     rsp.res = req.a - req.b;
			default:     rsp.res = req.a - req.b;
		endcase
		rsp.lt = req.a < req.c;
	end

endmodule

>>> design/bwsd_cnt_ram.sv
// Per-worker counter memory: one write and one registered read port.
// Entries not yet written read as zero (valid bits cleared by reset).
// Depends on bwsd_pkg.
module bwsd_cnt_ram #(
	parameter int DEPTH = bwsd_pkg::MAX_WORKERS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [bwsd_pkg::CNT_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [bwsd_pkg::CNT_W-1:0] rdata
);
	import bwsd_pkg::*;

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

>>> design/bwsd_ctrl.sv
// Sequencer: start sweep, own-counter attempt, min-counter scan, steal, length clip.
// Drives the shared ALU and the counter memory. Depends on bwsd_pkg.
module bwsd_ctrl #(
	parameter int MAX_WORKERS = bwsd_pkg::MAX_WORKERS_DEF,
	parameter int AW          = $clog2(MAX_WORKERS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bwsd_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_mode,
	input  logic [bwsd_pkg::WORKER_W-1:0] in_worker,
	output logic                          res_valid,
	output bwsd_pkg::res_t                res,
	input  logic                          out_free,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [bwsd_pkg::CNT_W-1:0]    ram_wdata,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [bwsd_pkg::CNT_W-1:0]    ram_rdata,
	output bwsd_pkg::alu_req_t            alu_req,
	input  bwsd_pkg::alu_rsp_t            alu_rsp
);
	import bwsd_pkg::*;

	ctrl_state_t         state_q, state_d;
	logic [WORKER_W-1:0] worker_q;
	logic [CNT_W-1:0]    step_q;
	logic [AW-1:0]       idx_q;
	logic [CNT_W-1:0]    acc_q;
	logic                cmp_vld_q;
	logic [AW-1:0]       cmp_idx_q;
	logic [CNT_W-1:0]    min_q;
	logic [AW-1:0]       minidx_q;
	logic [CNT_W-1:0]    cnt_q;
	status_t             sts_q;
	logic [VIC_W-1:0]    vic_q;
	logic [LEN_W-1:0]    len_q;

	logic             accept;
	logic             own_ok;
	logic             init_last;
	logic             scan_last;
	logic [CNT_W-1:0] total_ext;
	logic [LEN_W-1:0] clip_len;

	assign accept    = in_valid && in_ready;
	assign total_ext = {1'b0, cfg.total};
	assign own_ok    = 32'(in_worker) < 32'(cfg.n);
	assign init_last = 32'(idx_q) == 32'(MAX_WORKERS) - 32'd1;
	assign scan_last = (32'(idx_q) + 32'd1) >= 32'(cfg.n);
	// remaining items vs. batch size; alu_rsp.res holds total - index in CS_LEN
	assign clip_len  = ((|alu_rsp.res[CNT_W-1:LEN_W]) || (alu_rsp.res[LEN_W-1:0] > cfg.batch))
		? cfg.batch : alu_rsp.res[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = alu_rsp.res;
		ram_raddr = idx_q;
		alu_req   = '{op: ALU_ADD_SAT, a: ram_rdata, b: step_q, c: total_ext};
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode_t'(in_mode) == MODE_START) state_d = CS_INIT;
					else if (own_ok)                    state_d = CS_OWN_RD;
					else                                state_d = CS_SCAN;
				end
			end
			CS_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = (32'(idx_q) < 32'(cfg.n)) ? acc_q : '0;
				alu_req   = '{op: ALU_ADD_SAT, a: acc_q, b: {16'b0, cfg.batch}, c: total_ext};
				if (init_last) state_d = CS_OUT;
			end
			CS_OWN_RD: begin
				ram_raddr = AW'(worker_q);
				state_d   = CS_OWN_EVAL;
			end
			CS_OWN_EVAL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(worker_q);
				state_d   = alu_rsp.lt ? CS_LEN : CS_SCAN;
			end
			CS_SCAN: begin
				alu_req = '{op: ALU_ADD_SAT, a: ram_rdata, b: step_q, c: min_q};
				if (scan_last) state_d = CS_SCAN_END;
			end
			CS_SCAN_END: begin
				alu_req = '{op: ALU_ADD_SAT, a: ram_rdata, b: step_q, c: min_q};
				state_d = CS_STEAL;
			end
			CS_STEAL: begin
				alu_req   = '{op: ALU_ADD_SAT, a: min_q, b: step_q, c: total_ext};
				ram_we    = 1'b1;
				ram_waddr = minidx_q;
				state_d   = alu_rsp.lt ? CS_LEN : CS_OUT;
			end
			CS_LEN: begin
				alu_req = '{op: ALU_SUB, a: total_ext, b: cnt_q, c: total_ext};
				state_d = CS_OUT;
			end
			CS_OUT: begin
				res_valid = out_free;
				if (out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= (state_q == CS_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= idx_q;
		if (accept) begin
			worker_q <= in_worker;
			step_q   <= {25'b0, cfg.n} * {16'b0, cfg.batch};
			idx_q    <= '0;
			acc_q    <= '0;
		end
		// min search over returning read data; lowest index wins ties
		if (cmp_vld_q && ((cmp_idx_q == '0) || alu_rsp.lt)) begin
			min_q    <= ram_rdata;
			minidx_q <= cmp_idx_q;
		end
		unique case (state_q)
			CS_INIT: begin
				acc_q <= alu_rsp.res;
				idx_q <= idx_q + AW'(1);
				sts_q <= STS_STARTED;
				cnt_q <= '0;
				len_q <= '0;
				vic_q <= '0;
			end
			CS_OWN_EVAL: begin
				cnt_q <= ram_rdata;
				sts_q <= STS_OWN;
				vic_q <= worker_q;
				idx_q <= '0;
			end
			CS_SCAN: begin
				idx_q <= idx_q + AW'(1);
			end
			CS_STEAL: begin
				if (alu_rsp.lt) begin
					cnt_q <= min_q;
					sts_q <= STS_STOLEN;
					vic_q <= VIC_W'(minidx_q);
				end else begin
					cnt_q <= '0;
					sts_q <= STS_NOWORK;
					vic_q <= '0;
					len_q <= '0;
				end
			end
			CS_LEN: begin
				len_q <= clip_len;
			end
			default: ;
		endcase
	end

	assign res = '{status: sts_q, start_index: cnt_q[TOTAL_W-1:0], length: len_q,
		victim: vic_q};

endmodule

>>> design/batch_work_stealing_dispatcher_top.sv
// Batch work-stealing dispatcher, top level: config registers, output register,
// sequencer, shared ALU and counter memory. Depends on bwsd_pkg and submodules.
// A start word writes every counter across all MAX_WORKERS entries (one counter
// written per cycle); an own grant reads and updates the worker's own counter; a
// steal or no-work result follows a min scan over the active workers (one counter
// read per cycle). One word in flight; ready again in the cycle after the result is taken into the output register.
// Reset: async active low; counters read as zero, total 0, batch 1, workers 1.
module batch_work_stealing_dispatcher_top #(
	parameter int MAX_WORKERS = bwsd_pkg::MAX_WORKERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bwsd_pkg::IN_TDATA_W-1:0]    s_tdata,   // [3:0] worker, [7:4] zero
	input  logic                               s_tuser,   // [0] mode
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bwsd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [30:0] start_index,
	                                                      // [46:31] length,
	                                                      // [50:47] victim, [55:51] zero
	output logic [1:0]                         m_tuser,   // [1:0] status
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bwsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bwsd_pkg::TOTAL_W-1:0]       cfg_data
);
	import bwsd_pkg::*;

	localparam int AW = $clog2(MAX_WORKERS);

	logic [TOTAL_W-1:0] total_q;
	logic [BATCH_W-1:0] batch_q;
	logic [AWK_W-1:0]   workers_q;
	cfg_t               cfg;

	logic     out_vld_q;
	res_t     out_q;
	logic     out_free;
	logic     res_valid;
	res_t     res;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [CNT_W-1:0] ram_rdata;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	// config registers, always writable; the user must write them only while idle, the block itself does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			batch_q   <= BATCH_W'(1);
			workers_q <= AWK_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TOTAL:   total_q   <= cfg_data;
				CFG_BATCH:   batch_q   <= cfg_data[BATCH_W-1:0];
				CFG_WORKERS: workers_q <= cfg_data[AWK_W-1:0];
				default: ;
			endcase
		end
	end

	// effective values: zero batch/workers act as one, workers clamp to MAX_WORKERS
	always_comb begin
		cfg.total = total_q;
		cfg.batch = (batch_q == '0) ? BATCH_W'(1) : batch_q;
		if (workers_q == '0)
			cfg.n = WCNT_W'(1);
		else if (32'(workers_q) > 32'(MAX_WORKERS))
			cfg.n = WCNT_W'(MAX_WORKERS);
		else
			cfg.n = WCNT_W'(workers_q);
	end

	// output register decouples the sequencer from the sink
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.victim, out_q.length, out_q.start_index};

	bwsd_ctrl #(
		.MAX_WORKERS (MAX_WORKERS),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_worker (s_tdata[WORKER_W-1:0]),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp)
	);

	bwsd_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	bwsd_cnt_ram #(
		.DEPTH (MAX_WORKERS),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	// upper pad bits of the input word carry nothing
	logic unused_pad;
	assign unused_pad = |s_tdata[IN_TDATA_W-1:WORKER_W];

endmodule

>>> design/bwsd_chk.sv
// Port-level checker for the dispatcher, bound to the top level.
// Depends on bwsd_pkg.
module bwsd_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bwsd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser
);
	import bwsd_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one word in flight: not ready right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

	// start and no-work results carry an all-zero payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_STARTED || m_tuser == STS_NOWORK) |-> m_tdata == '0)
		else $error("nonzero payload on start or no-work result");

	// a granted batch is never empty
	a_grant_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_OWN || m_tuser == STS_STOLEN) |-> m_tdata[46:31] != '0)
		else $error("granted batch of length zero");

endmodule

bind batch_work_stealing_dispatcher_top bwsd_chk u_chk (.*);
